### sv/sha1_pkg.sv
// Package for the SHA-1 message digest unit: constants, types and round helpers.
// Used by all modules of the block; depends on nothing.
`default_nettype none
package sha1_pkg;
  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hefcdab89;
  localparam logic [31:0] H2 = 32'h98badcfe;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hc3d2e1f0;
  localparam logic [31:0] K0 = 32'h5a827999;
  localparam logic [31:0] K1 = 32'h6ed9eba1;
  localparam logic [31:0] K2 = 32'h8f1bbcdc;
  localparam logic [31:0] K3 = 32'hca62c1d6;
  localparam logic [7:0]  PadByte = 8'h80;

  // One classified input transaction, as queued between front and back.
  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       last;
  } sha1_item_t;

  // Round function and constant for round number r.
  function automatic logic [31:0] round_f(input logic [6:0] r, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    begin
      if (r < 7'd20) f = (b & c) | (~b & d);
      else if (r < 7'd40) f = b ^ c ^ d;
      else if (r < 7'd60) f = (b & c) | (b & d) | (c & d);
      else f = b ^ c ^ d;
      return f;
    end
  endfunction

  function automatic logic [31:0] round_k(input logic [6:0] r);
    logic [31:0] k;
    begin
      if (r < 7'd20) k = K0;
      else if (r < 7'd40) k = K1;
      else if (r < 7'd60) k = K2;
      else k = K3;
      return k;
    end
  endfunction
endpackage
`default_nettype wire

### sv/sha1_message_digest_unit.sv
// SHA-1 message digest unit, top level.
// Channels: s_axis carries one message byte per transaction with tuser marking
// it as a message byte and tlast ending the message; m_axis returns five digest
// words, most significant first, tlast on the fifth word.
// Throughput: the back end absorbs one byte at a time; the byte that fills
// a 64-byte block holds it while the block compresses, one round per cycle.
// After the message's last transaction is accepted, the back end pads the
// message (in a further block when the last byte filled one), appends the
// length (in a further block when it does not fit) and compresses before the
// first digest word appears; then five output transactions follow, one per
// cycle at best. A four-entry queue decouples the input side so bytes keep
// being accepted while a block compresses.
// Reset clears the queue, the chaining values to the SHA-1 initial values,
// and all counters. When the receiver stalls, the current digest word holds
// and the back end waits; the input queue fills and then deasserts tready.
// Depends on sha1_pkg, sha1_fifo and sha1_core.
`default_nettype none
module sha1_message_digest_unit
  import sha1_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [7:0]  s_axis_tdata,   // data_byte
  input  wire         s_axis_tuser,   // byte_valid
  input  wire         s_axis_tlast,   // last_byte
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [39:0] m_axis_tdata,   // digest_word [31:0], word_index [34:32], zeros
  output logic        m_axis_tlast    // last_word
);
  sha1_item_t in_item, q_item;
  logic       q_valid, q_ready;
  logic [31:0] word;
  logic [2:0]  idx;

  // Front end: classify each transaction into a queued item.
  assign in_item = '{data: s_axis_tdata, valid: s_axis_tuser, last: s_axis_tlast};

  sha1_fifo u_fifo (
    .clk_i, .rst_ni,
    .wr_valid_i(s_axis_tvalid), .wr_ready_o(s_axis_tready), .wr_item_i(in_item),
    .rd_valid_o(q_valid), .rd_ready_i(q_ready), .rd_item_o(q_item)
  );

  sha1_core u_core (
    .clk_i, .rst_ni,
    .in_valid_i(q_valid), .in_ready_o(q_ready), .in_item_i(q_item),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .out_word_o(word), .out_index_o(idx), .out_last_o(m_axis_tlast)
  );

  assign m_axis_tdata = {5'd0, idx, word};
endmodule
`default_nettype wire

### sv/sha1_fifo.sv
// Short queue between the input front end and the hashing back end.
// Depends on sha1_pkg for the item type.
`default_nettype none
module sha1_fifo
  import sha1_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        wr_valid_i,
  output logic       wr_ready_o,
  input  sha1_item_t wr_item_i,
  output logic       rd_valid_o,
  input  wire        rd_ready_i,
  output sha1_item_t rd_item_o
);
  sha1_item_t  mem_q [4];
  logic [1:0]  wp_q, rp_q;
  logic [2:0]  cnt_q;
  logic        wr, rd;

  assign wr_ready_o = (cnt_q != 3'd4);
  assign rd_valid_o = (cnt_q != 3'd0);
  assign rd_item_o  = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  // Storage for queued transactions.
  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_item_i;
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (wr) wp_q <= wp_q + 2'd1;
      if (rd) rp_q <= rp_q + 2'd1;
      if (wr && !rd) cnt_q <= cnt_q + 3'd1;
      else if (rd && !wr) cnt_q <= cnt_q - 3'd1;
    end
  end
endmodule
`default_nettype wire

### sv/sha1_core.sv
// Back end: block assembly, padding, 80-round compression and digest output.
// Depends on sha1_pkg.
`default_nettype none
module sha1_core
  import sha1_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  sha1_item_t  in_item_i,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic [31:0] out_word_o,
  output logic [2:0]  out_index_o,
  output logic        out_last_o
);
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StRound = 3'd1;
  localparam logic [2:0] StPad = 3'd2;
  localparam logic [2:0] StLen = 3'd3;
  localparam logic [2:0] StOut = 3'd4;

  logic [2:0]  state_q, state_d;
  logic [31:0] h_q [5];
  logic [31:0] w_q [16];
  logic [31:0] a_q, b_q, c_q, d_q, e_q;
  logic [6:0]  rnd_q;
  logic [5:0]  pos_q;
  logic [60:0] len_q;
  logic        fin_q;     // the message has ended; padding and length follow
  logic        extra_q;   // the padding block had no room for the length
  logic        lenblk_q;  // the block under compression carries the length
  logic [2:0]  oidx_q;

  logic        take;
  logic        last_rnd;
  logic [31:0] wnew, tsum, bword;
  logic [3:0]  wi;
  logic [4:0]  sh;
  logic [63:0] bits;

  assign in_ready_o  = (state_q == StIdle);
  assign take        = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == StOut);
  assign out_word_o  = h_q[oidx_q];
  assign out_index_o = oidx_q;
  assign out_last_o  = (oidx_q == 3'd4);

  assign last_rnd = (rnd_q == 7'd79);
  assign wi    = pos_q[5:2];
  assign sh    = 5'd24 - {pos_q[1:0], 3'b000};
  assign bits  = {len_q, 3'b000};
  assign wnew  = {w_q[13][30:0] ^ w_q[8][30:0] ^ w_q[2][30:0] ^ w_q[0][30:0],
                  w_q[13][31] ^ w_q[8][31] ^ w_q[2][31] ^ w_q[0][31]};
  assign tsum  = {a_q[26:0], a_q[31:27]} + round_f(rnd_q, b_q, c_q, d_q) + e_q
                 + round_k(rnd_q) + w_q[0];

  // A byte at the start of a word replaces it; later bytes merge into it.
  always_comb begin
    bword = w_q[wi];
    if (pos_q[1:0] == 2'd0) bword = '0;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (take) begin
        if (in_item_i.valid && pos_q == 6'd63) state_d = StRound;
        else if (in_item_i.last) state_d = StPad;
      end
      StRound: if (last_rnd) begin
        if (!fin_q) state_d = StIdle;
        else if (lenblk_q) state_d = StOut;
        else if (extra_q) state_d = StLen;
        else state_d = StPad;
      end
      StPad:   state_d = (pos_q >= 6'd56) ? StRound : StLen;
      StLen:   state_d = StRound;
      StOut:   if (out_ready_i && oidx_q == 3'd4) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // Control registers, chaining values and counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      h_q[0] <= H0; h_q[1] <= H1; h_q[2] <= H2; h_q[3] <= H3; h_q[4] <= H4;
      pos_q <= '0; len_q <= '0; rnd_q <= '0; fin_q <= 1'b0; extra_q <= 1'b0;
      lenblk_q <= 1'b0; oidx_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == StRound) rnd_q <= rnd_q + 7'd1;
      else rnd_q <= '0;
      unique case (state_q)
        StIdle: if (take) begin
          fin_q <= in_item_i.last;
          if (in_item_i.valid) begin
            len_q <= len_q + 61'd1;
            pos_q <= pos_q + 6'd1;
          end
        end
        StRound: if (last_rnd) begin
          h_q[0] <= h_q[0] + tsum;
          h_q[1] <= h_q[1] + a_q;
          h_q[2] <= h_q[2] + {b_q[1:0], b_q[31:2]};
          h_q[3] <= h_q[3] + c_q;
          h_q[4] <= h_q[4] + d_q;
        end
        StPad: begin
          pos_q <= '0;
          extra_q <= (pos_q >= 6'd56);
        end
        StLen: lenblk_q <= 1'b1;
        StOut: if (out_ready_i) begin
          if (oidx_q == 3'd4) begin
            h_q[0] <= H0; h_q[1] <= H1; h_q[2] <= H2; h_q[3] <= H3; h_q[4] <= H4;
            pos_q <= '0; len_q <= '0; fin_q <= 1'b0; extra_q <= 1'b0;
            lenblk_q <= 1'b0; oidx_q <= '0;
          end else begin
            oidx_q <= oidx_q + 3'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // Message schedule window and working variables.
  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: if (take && in_item_i.valid) begin
        w_q[wi] <= bword | ({24'd0, in_item_i.data} << sh);
      end
      StRound: begin
        for (int j = 0; j < 15; j++) w_q[j] <= w_q[j+1];
        w_q[15] <= wnew;
        a_q <= tsum; b_q <= a_q; c_q <= {b_q[1:0], b_q[31:2]}; d_q <= c_q; e_q <= d_q;
      end
      StPad: begin
        for (int j = 0; j < 16; j++)
          if (4'(j) > wi) w_q[j] <= '0;
        w_q[wi] <= bword | ({24'd0, PadByte} << sh);
      end
      StLen: begin
        // A length-only block starts from zeros.
        if (extra_q) begin
          for (int j = 0; j < 14; j++) w_q[j] <= '0;
        end
        w_q[14] <= bits[63:32];
        w_q[15] <= bits[31:0];
      end
      default: ;
    endcase
    // Load the working variables as a compression begins.
    if (state_d == StRound && state_q != StRound) begin
      a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2]; d_q <= h_q[3]; e_q <= h_q[4];
    end
  end
endmodule
`default_nettype wire
